// File: rtl/tee_pkg.sv
// Shared types, constants and character tables for the text escape encoder.
package tee_pkg;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_XML  = 2'd1;
  localparam logic [1:0] MODE_HTTP = 2'd2;

  // Token queue between classifier and expander; depth is a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_APOS,
    KIND_QUOT,
    KIND_PLUS,
    KIND_PCT
  } tee_kind_e;

  typedef struct packed {
    tee_kind_e  kind;
    logic [7:0] data;
  } tee_tok_t;

  function automatic logic [7:0] tee_hex(input logic [3:0] n);
    logic [7:0] w;
    w = {4'h0, n};
    return (n < 4'd10) ? (8'h30 + w) : (8'h57 + w);
  endfunction

  function automatic logic [2:0] tee_len(input tee_kind_e kind);
    case (kind)
      KIND_LT, KIND_GT: return 3'd4;
      KIND_AMP:         return 3'd5;
      KIND_APOS:        return 3'd6;
      KIND_QUOT:        return 3'd6;
      KIND_PCT:         return 3'd3;
      default:          return 3'd1;
    endcase
  endfunction

  // Byte number idx of the expansion of one token.
  function automatic logic [7:0] tee_char(input tee_kind_e kind, input logic [7:0] data,
                                          input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h26; // '&'
    case (kind)
      KIND_PASS: c = data;
      KIND_PLUS: c = 8'h2B;
      KIND_PCT: begin
        case (idx)
          3'd0:    c = 8'h25;
          3'd1:    c = tee_hex(data[7:4]);
          default: c = tee_hex(data[3:0]);
        endcase
      end
      KIND_LT: begin
        case (idx)
          3'd1:    c = 8'h6C; // l
          3'd2:    c = 8'h74; // t
          3'd3:    c = 8'h3B;
          default: c = 8'h26;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd1:    c = 8'h67; // g
          3'd2:    c = 8'h74; // t
          3'd3:    c = 8'h3B;
          default: c = 8'h26;
        endcase
      end
      KIND_AMP: begin
        case (idx)
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h6D; // m
          3'd3:    c = 8'h70; // p
          3'd4:    c = 8'h3B;
          default: c = 8'h26;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h70; // p
          3'd3:    c = 8'h6F; // o
          3'd4:    c = 8'h73; // s
          3'd5:    c = 8'h3B;
          default: c = 8'h26;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd1:    c = 8'h71; // q
          3'd2:    c = 8'h75; // u
          3'd3:    c = 8'h6F; // o
          3'd4:    c = 8'h74; // t
          3'd5:    c = 8'h3B;
          default: c = 8'h26;
        endcase
      end
      default: c = data;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tee_front.sv
// Front end: mode register, input acceptance and byte classification into tokens.
module tee_front import tee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_escape_mode_i,
  output logic       cfg_ready_o,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       push_o,
  output tee_tok_t   push_tok_o
);

  logic [1:0] mode_q;
  logic       is_alnum;
  tee_kind_e  kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_escape_mode_i;
    end
  end

  assign is_alnum = (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) ||
                    (in_byte_i >= 8'h41 && in_byte_i <= 8'h5A) ||
                    (in_byte_i >= 8'h61 && in_byte_i <= 8'h7A);

  always_comb begin
    kind = KIND_PASS;
    if (mode_q == MODE_XML) begin
      case (in_byte_i)
        8'h3C:   kind = KIND_LT;
        8'h3E:   kind = KIND_GT;
        8'h26:   kind = KIND_AMP;
        8'h27:   kind = KIND_APOS;
        8'h22:   kind = KIND_QUOT;
        default: kind = KIND_PASS;
      endcase
    end else if (!is_alnum) begin
      kind = (in_byte_i == 8'h20) ? KIND_PLUS : KIND_PCT;
    end
  end

  assign in_stall_o      = q_full_i;
  // Drop the item in mode none and in the unused mode code.
  assign push_o          = in_valid_i && !q_full_i &&
                           (mode_q == MODE_XML || mode_q == MODE_HTTP);
  assign push_tok_o.kind = kind;
  assign push_tok_o.data = in_byte_i;

endmodule

// File: rtl/tee_queue.sv
// Short token queue between the classifier and the expander.
module tee_queue import tee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tee_tok_t push_tok_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tee_tok_t head_o
);

  tee_tok_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q;
  logic [QPTR_W-1:0]   rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_tok_i;
  end

endmodule

// File: rtl/tee_back.sv
// Back end: expands the head token into the output register, one byte per cycle unless stalled.
module tee_back import tee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  tee_tok_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  input  logic       out_stall_i
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q;
  logic [2:0] idx_q;
  logic       load;
  logic       fire;
  logic       last;

  assign load  = !out_valid_q || !out_stall_i;
  assign fire  = load && !empty_i;
  assign last  = (idx_q == tee_len(head_i.kind) - 3'd1);
  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) out_valid_q <= !empty_i;
      // Advance within the token, restart on its last byte.
      if (fire) idx_q <= last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= tee_char(head_i.kind, head_i.data, idx_q);
      run_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule

// File: rtl/text_escape_encoder.sv
// Top level of the text escape encoder: XML entity or HTTP form percent encoding.
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_escape_mode_i[1:0]
//   in        in         in_valid_i / in_stall_o    in_byte_i[7:0]
//   out       out        out_valid_o / out_stall_i  out_byte_o[7:0], run_last_o
//
// An input byte expands to N output bytes (N = 1, 3, 4, 5 or 6), one per cycle from the
// expander while out_stall_i is low, so sustained input slows with N; plain bytes go one
// per cycle. In mode none an input byte is taken each cycle the queue is not full, and
// emits nothing. An input transfer is queued, then expanded into the output register; a
// four-entry token queue lets the input keep flowing while the output is stalled until the
// queue fills. Reset clears the mode to none, the queue and the output register.
module text_escape_encoder import tee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_escape_mode_i,
  output logic       cfg_ready_o,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  input  logic       out_stall_i
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  tee_tok_t push_tok;
  tee_tok_t head_tok;

  tee_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_escape_mode_i (cfg_escape_mode_i),
    .cfg_ready_o       (cfg_ready_o),
    .in_valid_i        (in_valid_i),
    .in_byte_i         (in_byte_i),
    .in_stall_o        (in_stall_o),
    .q_full_i          (q_full),
    .push_o            (push),
    .push_tok_o        (push_tok)
  );

  tee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_tok)
  );

  tee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_tok),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: rtl/tee_checker.sv
// Port-level checker for the text escape encoder, bound to the top level.
module tee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic [1:0] cfg_escape_mode_i,
  input logic       cfg_ready_o,
  input logic       in_valid_i,
  input logic [7:0] in_byte_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       out_stall_i
);

  logic cfg_xfer;
  logic in_xfer;

  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign in_xfer  = in_valid_i && !in_stall_o && (in_byte_i == in_byte_i) &&
                    (cfg_escape_mode_i == cfg_escape_mode_i || !cfg_xfer);

  // A stalled output transfer holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_last_o))
    else $error("output changed while stalled");

  // The next byte of an expansion follows right after a non-final transfer.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("expansion broken off");

  // Non-final bytes are only escape starts, entity letters or hex digits.
  a_mid_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |->
      (out_byte_o == 8'h26 || out_byte_o == 8'h25 ||
       (out_byte_o >= 8'h30 && out_byte_o <= 8'h39) ||
       (out_byte_o >= 8'h61 && out_byte_o <= 8'h7A)))
    else $error("unexpected byte inside an expansion");

  // Leaving reset finds the output register empty.
  a_rst_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // The register port never holds off a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i || in_xfer |-> cfg_ready_o)
    else $error("register write held off");

endmodule

bind text_escape_encoder tee_checker u_tee_checker (.*);
